[hdl/bpfl_pkg.sv]
// Package for the buffer pool free-list allocator.
// Holds shared constants, request and status codes, and the structs passed between modules.
// No dependencies.
package bpfl_pkg;

  // Address and result field widths fixed by the request and response formats.
  localparam int unsigned ADDR_W    = 48;
  localparam int unsigned BLK_IDX_W = 6;

  // Default pool geometry.
  localparam int unsigned NUM_BLOCKS_DEF  = 64;
  localparam int unsigned BLOCK_SHIFT_DEF = 16;

  // Request kinds. The fourth code is unused and answered as not found.
  typedef enum logic [1:0] {
    KIND_ALLOC  = 2'd0,
    KIND_FREE   = 2'd1,
    KIND_LOOKUP = 2'd2
  } kind_e;

  // Response status codes.
  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_EMPTY       = 2'd1,
    ST_NOT_FOUND   = 2'd2,
    ST_DOUBLE_FREE = 2'd3
  } status_e;

  // Decoded control fields of a registered request.
  typedef struct packed {
    kind_e kind;
    logic  wait_empty;
    logic  idx_ok;
  } req_ctl_t;

  // One response transaction.
  typedef struct packed {
    status_e              status;
    logic [BLK_IDX_W-1:0] result_index;
    logic [ADDR_W-1:0]    buffer_address;
    logic                 wake;
  } result_t;

endpackage

[hdl/bpfl_req_if.sv]
// Request channel of the buffer pool allocator: valid/ready plus request payload.
// Depends on bpfl_pkg for field widths.
interface bpfl_req_if
  import bpfl_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [1:0]           kind;
  logic                 wait_if_empty;
  logic [BLK_IDX_W-1:0] block_index;
  logic [ADDR_W-1:0]    address;

  modport source (output valid, kind, wait_if_empty, block_index, address, input ready);
  modport sink   (input valid, kind, wait_if_empty, block_index, address, output ready);
endinterface

[hdl/bpfl_rsp_if.sv]
// Response channel of the buffer pool allocator: valid/ready plus response payload.
// Depends on bpfl_pkg for field widths.
interface bpfl_rsp_if
  import bpfl_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [1:0]           status;
  logic [BLK_IDX_W-1:0] result_index;
  logic [ADDR_W-1:0]    buffer_address;
  logic                 wake;

  modport source (output valid, status, result_index, buffer_address, wake, input ready);
  modport sink   (input valid, status, result_index, buffer_address, wake, output ready);
endinterface

[hdl/buffer_pool_free_list_allocator.sv]
// Buffer pool free-list allocator, top level.
// Registers: a request register and a response register; an accepted request waits in its
// register until the response register is free or drains, then its response is loaded.
// Throughput: one request per cycle unless rsp stalls; free list head and link read ahead.
// Reset: asynchronous; all blocks free, highest index at the head, pool base zero.
// No memory clearing pass: never-allocated blocks are tracked by a boundary counter.
// Depends on bpfl_pkg, bpfl_req_if, bpfl_rsp_if, bpfl_req_stage and bpfl_core.
module buffer_pool_free_list_allocator
  import bpfl_pkg::*;
#(
  parameter int unsigned NUM_BLOCKS  = NUM_BLOCKS_DEF,
  parameter int unsigned BLOCK_SHIFT = BLOCK_SHIFT_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [ADDR_W-1:0] cfg_wdata_i,
  bpfl_req_if.sink          req,
  bpfl_rsp_if.source        rsp
);

  localparam int unsigned IDX_W = $clog2(NUM_BLOCKS);

  logic [ADDR_W-1:0] pool_base_q;
  logic              s1_valid;
  req_ctl_t          s1_ctl;
  logic [IDX_W-1:0]  s1_idx;
  logic              ld;
  logic [IDX_W-1:0]  ld_idx;
  logic              fire;

  // Pool base configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_base_q <= '0;
    end else if (cfg_we_i) begin
      pool_base_q <= cfg_wdata_i;
    end
  end

  // Request register and block decode.
  bpfl_req_stage #(
    .NUM_BLOCKS  (NUM_BLOCKS),
    .BLOCK_SHIFT (BLOCK_SHIFT)
  ) u_req_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req         (req),
    .pool_base_i (pool_base_q),
    .advance_i   (fire),
    .valid_o     (s1_valid),
    .ctl_o       (s1_ctl),
    .idx_o       (s1_idx),
    .ld_o        (ld),
    .ld_idx_o    (ld_idx)
  );

  // Free-list execution and response register.
  bpfl_core #(
    .NUM_BLOCKS  (NUM_BLOCKS),
    .BLOCK_SHIFT (BLOCK_SHIFT)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pool_base_i (pool_base_q),
    .s1_valid_i  (s1_valid),
    .s1_ctl_i    (s1_ctl),
    .s1_idx_i    (s1_idx),
    .ld_i        (ld),
    .ld_idx_i    (ld_idx),
    .fire_o      (fire),
    .rsp         (rsp)
  );

endmodule

[hdl/bpfl_ram.sv]
// Simple dual-port RAM: one write port, one registered read port with write-first bypass.
// No package dependencies.
module bpfl_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 6
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port; a write to the same address in the same cycle is returned directly.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      if (we_i && (waddr_i == raddr_i)) begin
        rdata_q <= wdata_i;
      end else begin
        rdata_q <= mem[raddr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/bpfl_req_stage.sv]
// Request input register of the allocator: decodes the block index from a free or look-up.
// Depends on bpfl_pkg and bpfl_req_if.
module bpfl_req_stage
  import bpfl_pkg::*;
#(
  parameter int unsigned NUM_BLOCKS  = NUM_BLOCKS_DEF,
  parameter int unsigned BLOCK_SHIFT = BLOCK_SHIFT_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  bpfl_req_if.sink                      req,
  input  logic [ADDR_W-1:0]             pool_base_i,
  input  logic                          advance_i,
  output logic                          valid_o,
  output req_ctl_t                      ctl_o,
  output logic [$clog2(NUM_BLOCKS)-1:0] idx_o,
  output logic                          ld_o,
  output logic [$clog2(NUM_BLOCKS)-1:0] ld_idx_o
);

  localparam int unsigned IDX_W = $clog2(NUM_BLOCKS);
  localparam logic [ADDR_W-1:0] POOL_SIZE = ADDR_W'(NUM_BLOCKS) << BLOCK_SHIFT;

  logic              valid_q, valid_d;
  req_ctl_t          ctl_q, ctl_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [ADDR_W-1:0] offset;
  logic              in_pool;
  logic              blk_ok;
  logic              ld;

  // Offset of a look-up address into the pool, modulo the address width.
  assign offset  = req.address - pool_base_i;
  assign in_pool = offset < POOL_SIZE;
  assign blk_ok  = 32'(req.block_index) < 32'(NUM_BLOCKS);

  // Pick the block that the request names; out-of-range requests point at block zero.
  always_comb begin
    ctl_d.kind       = kind_e'(req.kind);
    ctl_d.wait_empty = req.wait_if_empty;
    ctl_d.idx_ok     = 1'b0;
    idx_d            = '0;
    case (kind_e'(req.kind))
      KIND_FREE: begin
        ctl_d.idx_ok = blk_ok;
        idx_d        = blk_ok ? IDX_W'(req.block_index) : '0;
      end
      KIND_LOOKUP: begin
        ctl_d.idx_ok = in_pool;
        idx_d        = in_pool ? offset[BLOCK_SHIFT +: IDX_W] : '0;
      end
      default: begin
        ctl_d.idx_ok = 1'b0;
        idx_d        = '0;
      end
    endcase
  end

  // Handshake: the register takes a new transaction when empty or when its item moves on.
  assign req.ready = !valid_q || advance_i;
  assign ld        = req.valid && req.ready;
  assign valid_d   = ld || (valid_q && !advance_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload register.
  always_ff @(posedge clk_i) begin
    if (ld) begin
      ctl_q <= ctl_d;
      idx_q <= idx_d;
    end
  end

  assign valid_o  = valid_q;
  assign ctl_o    = ctl_q;
  assign idx_o    = idx_q;
  assign ld_o     = ld;
  assign ld_idx_o = idx_d;

endmodule

[hdl/bpfl_core.sv]
// Allocator core: free-list state, link and free-map memories, and the response register.
// Depends on bpfl_pkg, bpfl_rsp_if and bpfl_ram.
module bpfl_core
  import bpfl_pkg::*;
#(
  parameter int unsigned NUM_BLOCKS  = NUM_BLOCKS_DEF,
  parameter int unsigned BLOCK_SHIFT = BLOCK_SHIFT_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [ADDR_W-1:0]             pool_base_i,
  input  logic                          s1_valid_i,
  input  req_ctl_t                      s1_ctl_i,
  input  logic [$clog2(NUM_BLOCKS)-1:0] s1_idx_i,
  input  logic                          ld_i,
  input  logic [$clog2(NUM_BLOCKS)-1:0] ld_idx_i,
  output logic                          fire_o,
  bpfl_rsp_if.source                    rsp
);

  localparam int unsigned IDX_W = $clog2(NUM_BLOCKS);
  localparam int unsigned CNT_W = $clog2(NUM_BLOCKS + 1);

  // Free-list state. Blocks below fresh_q were never handed out: they are free and
  // their links still point at the next lower block, so the memories hold nothing for them.
  logic [IDX_W-1:0] head_q, head_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] fresh_q, fresh_d;
  logic             need_q, need_d;
  logic             out_valid_q, out_valid_d;
  result_t          out_q, res;
  logic             fresh_hit_q;

  logic             fire;
  logic             pop, push;
  logic             pop_fresh;
  logic [IDX_W-1:0] link_rd;
  logic             free_rd;
  logic             free_bit;
  logic [IDX_W-1:0] res_blk;
  logic [ADDR_W-1:0] blk_addr;

  // The held item executes when the response register is free or drains this cycle.
  assign fire   = s1_valid_i && (!out_valid_q || rsp.ready);
  assign fire_o = fire;

  assign pop_fresh = CNT_W'(head_q) < fresh_q;
  assign free_bit  = fresh_hit_q || free_rd;

  // Base address of the block named in the response.
  assign res_blk  = (s1_ctl_i.kind == KIND_ALLOC) ? head_q : s1_idx_i;
  assign blk_addr = pool_base_i + (ADDR_W'(res_blk) << BLOCK_SHIFT);

  // Request execution and next-state logic.
  always_comb begin
    res.status         = ST_NOT_FOUND;
    res.result_index   = '0;
    res.buffer_address = '0;
    res.wake           = 1'b0;
    pop                = 1'b0;
    push               = 1'b0;
    need_d             = need_q;
    case (s1_ctl_i.kind)
      KIND_ALLOC: begin
        if (cnt_q == '0) begin
          res.status = ST_EMPTY;
          if (s1_ctl_i.wait_empty) begin
            need_d = 1'b1;
          end
        end else begin
          pop                = 1'b1;
          res.status         = ST_OK;
          res.result_index   = BLK_IDX_W'(head_q);
          res.buffer_address = blk_addr;
        end
      end
      KIND_FREE: begin
        if (!s1_ctl_i.idx_ok) begin
          res.status = ST_NOT_FOUND;
        end else if (free_bit) begin
          res.status = ST_DOUBLE_FREE;
        end else begin
          push       = 1'b1;
          res.status = ST_OK;
          if (need_q) begin
            need_d   = 1'b0;
            res.wake = 1'b1;
          end
        end
      end
      KIND_LOOKUP: begin
        if (s1_ctl_i.idx_ok && !free_bit) begin
          res.status         = ST_OK;
          res.result_index   = BLK_IDX_W'(s1_idx_i);
          res.buffer_address = blk_addr;
        end
      end
      default: begin
        res.status = ST_NOT_FOUND;
      end
    endcase
    if (!fire) begin
      pop    = 1'b0;
      push   = 1'b0;
      need_d = need_q;
    end
  end

  // Head, count and fresh boundary updates for pop and push.
  always_comb begin
    head_d  = head_q;
    cnt_d   = cnt_q;
    fresh_d = fresh_q;
    if (pop) begin
      cnt_d = cnt_q - CNT_W'(1);
      if (pop_fresh) begin
        fresh_d = CNT_W'(head_q);
        head_d  = (head_q == '0) ? '0 : head_q - IDX_W'(1);
      end else begin
        head_d = link_rd;
      end
    end else if (push) begin
      cnt_d  = cnt_q + CNT_W'(1);
      head_d = s1_idx_i;
    end
  end

  // Link memory, always reading the entry of the next head.
  bpfl_ram #(
    .DEPTH (NUM_BLOCKS),
    .WIDTH (IDX_W)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (push),
    .waddr_i (s1_idx_i),
    .wdata_i (head_q),
    .re_i    (1'b1),
    .raddr_i (head_d),
    .rdata_o (link_rd)
  );

  // Free map of handed-out blocks, read for the incoming request.
  bpfl_ram #(
    .DEPTH (NUM_BLOCKS),
    .WIDTH (1)
  ) u_free_ram (
    .clk_i   (clk_i),
    .we_i    (pop || push),
    .waddr_i (pop ? head_q : s1_idx_i),
    .wdata_i (push),
    .re_i    (ld_i),
    .raddr_i (ld_idx_i),
    .rdata_o (free_rd)
  );

  // A block still in the never-allocated region reads as free.
  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      fresh_hit_q <= CNT_W'(ld_idx_i) < fresh_d;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= IDX_W'(NUM_BLOCKS - 1);
      cnt_q       <= CNT_W'(NUM_BLOCKS);
      fresh_q     <= CNT_W'(NUM_BLOCKS);
      need_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      head_q      <= head_d;
      cnt_q       <= cnt_d;
      fresh_q     <= fresh_d;
      need_q      <= need_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Response register.
  assign out_valid_d = fire || (out_valid_q && !rsp.ready);

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= res;
    end
  end

  assign rsp.valid          = out_valid_q;
  assign rsp.status         = out_q.status;
  assign rsp.result_index   = out_q.result_index;
  assign rsp.buffer_address = out_q.buffer_address;
  assign rsp.wake           = out_q.wake;

endmodule
